// ===== rtl/assert_macros.svh =====
// assertion macros of the line rasterizer, used by its top-level rtl file
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/blr_pkg.sv =====
// shared constants, codes and types of the line rasterizer
// no dependencies
`default_nettype none

package blr_pkg;

	localparam int MAX_DIM   = 64;
	localparam int COORD_W   = $clog2(MAX_DIM);
	localparam int IN_W      = 8;
	localparam int COLOR_W   = 8;
	localparam int WIN_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W    = COORD_W + 3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = CFG_IDX_W'(1);

	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SETUP,
		S_RUN,
		S_REJECT
	} state_t;

	// major axis a, minor axis b
	typedef struct packed {
		logic [COORD_W-1:0] a_start;
		logic [COORD_W-1:0] a_end;
		logic [COORD_W-1:0] b_start;
		logic [COORD_W-1:0] dmaj;
		logic [COORD_W-1:0] dmin;
		logic               sa_neg;
		logic               sb_neg;
		logic               ymajor;
	} step_load_t;

	typedef struct packed {
		logic load;
		logic advance;
	} step_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/blr_intf.sv =====
// channel interfaces of the line rasterizer: command, pixel and config write
// depends on blr_pkg
`default_nettype none

interface blr_cmd_if;
	logic                            valid;
	logic                            ready;
	logic signed [blr_pkg::IN_W-1:0] start_x;
	logic signed [blr_pkg::IN_W-1:0] start_y;
	logic signed [blr_pkg::IN_W-1:0] end_x;
	logic signed [blr_pkg::IN_W-1:0] end_y;
	logic [blr_pkg::COLOR_W-1:0]     pen_color;

	modport source (output valid, start_x, start_y, end_x, end_y, pen_color, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, pen_color, output ready);
endinterface

interface blr_pix_if;
	logic                        valid;
	logic                        ready;
	logic [blr_pkg::COORD_W-1:0] pixel_x;
	logic [blr_pkg::COORD_W-1:0] pixel_y;
	logic [blr_pkg::COLOR_W-1:0] pixel_color;
	logic                        status;
	logic                        last;

	modport source (output valid, pixel_x, pixel_y, pixel_color, status, last, input ready);
	modport sink (input valid, pixel_x, pixel_y, pixel_color, status, last, output ready);
endinterface

interface blr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [blr_pkg::CFG_IDX_W-1:0] index;
	logic [blr_pkg::WIN_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/blr_stepper.sv =====
// stepping unit of the line rasterizer: one Bresenham step along the major axis per advance
// depends on blr_pkg
`default_nettype none

module blr_stepper (
	input  wire logic                        clk,
	input  wire blr_pkg::step_load_t         load_data,
	input  wire blr_pkg::step_ctrl_t         ctrl,
	output logic [blr_pkg::COORD_W-1:0]      pix_x,
	output logic [blr_pkg::COORD_W-1:0]      pix_y,
	output logic                             at_end
);
	import blr_pkg::*;

	logic [COORD_W-1:0] a_q;
	logic [COORD_W-1:0] a_end_q;
	logic [COORD_W-1:0] b_q;
	logic [COORD_W-1:0] dmaj_q;
	logic [COORD_W-1:0] dmin_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               sa_neg_q;
	logic               sb_neg_q;
	logic               ymajor_q;

	logic [FRAC_W-1:0]  frac_init;
	logic [FRAC_W-1:0]  frac_next;
	logic [FRAC_W-1:0]  maj_term;
	logic [COORD_W-1:0] a_inc;
	logic [COORD_W-1:0] b_inc;
	logic               minor_step;

	// frac starts at 2*dmin - dmaj
	assign frac_init = FRAC_W'({load_data.dmin, 1'b0}) - FRAC_W'(load_data.dmaj);

	assign minor_step = !frac_q[FRAC_W-1];
	assign maj_term   = minor_step ? FRAC_W'({dmaj_q, 1'b0}) : '0;
	assign frac_next  = frac_q + FRAC_W'({dmin_q, 1'b0}) - maj_term;

	// step of one in either direction
	assign a_inc = sa_neg_q ? {COORD_W{1'b1}} : COORD_W'(1);
	assign b_inc = sb_neg_q ? {COORD_W{1'b1}} : COORD_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q      <= load_data.a_start;
			a_end_q  <= load_data.a_end;
			b_q      <= load_data.b_start;
			dmaj_q   <= load_data.dmaj;
			dmin_q   <= load_data.dmin;
			frac_q   <= frac_init;
			sa_neg_q <= load_data.sa_neg;
			sb_neg_q <= load_data.sb_neg;
			ymajor_q <= load_data.ymajor;
		end else if (ctrl.advance) begin
			a_q    <= a_q + a_inc;
			frac_q <= frac_next;
			if (minor_step) begin
				b_q <= b_q + b_inc;
			end
		end
	end

	assign pix_x  = ymajor_q ? b_q : a_q;
	assign pix_y  = ymajor_q ? a_q : b_q;
	assign at_end = (a_q == a_end_q);

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_rasterizer.sv =====
// line rasterizer top level: window registers, command sequencer, stepping unit
// depends on blr_pkg, blr_intf, blr_stepper and assert_macros.svh
`default_nettype none

// Takes one line command at a time and emits its pixels in drawing order on
// the pixel channel, last set on the final one. A command with an end point
// outside the window gives one result with status set and zero coordinates.
// Lines with equal columns or equal rows run from the smaller to the larger
// coordinate; others step from start to end. cmd.ready is high only while
// the block is idle: a line or a rejected command occupies it until its
// last result is taken by the pixel sink, since the single stepping unit
// produces one pixel per cycle, while the sink accepts, after a window
// check state and a setup state. Window registers are written over cfg at
// any time the block is idle; values above 64 act as 64.
module bresenham_line_rasterizer (
	input wire logic   clk,
	input wire logic   arst_n,
	blr_cfg_if.sink    cfg,
	blr_cmd_if.sink    cmd,
	blr_pix_if.source  pixel
);
	import blr_pkg::*;

	`include "assert_macros.svh"

	state_t state_q;
	state_t state_d;

	logic [WIN_W-1:0] win_w_q;
	logic [WIN_W-1:0] win_h_q;
	logic [WIN_W-1:0] w_eff;
	logic [WIN_W-1:0] h_eff;

	logic [IN_W-1:0]    sx_q;
	logic [IN_W-1:0]    sy_q;
	logic [IN_W-1:0]    ex_q;
	logic [IN_W-1:0]    ey_q;
	logic [COLOR_W-1:0] color_q;

	logic [COORD_W-1:0] adx_q;
	logic [COORD_W-1:0] ady_q;
	logic               sxn_q;
	logic               syn_q;

	logic [COORD_W:0]   dx;
	logic [COORD_W:0]   dy;
	logic [COORD_W:0]   dx_neg;
	logic [COORD_W:0]   dy_neg;
	logic               in_win;

	step_load_t         load_data;
	step_ctrl_t         step_ctrl;
	logic [COORD_W-1:0] step_x;
	logic [COORD_W-1:0] step_y;
	logic               at_end;

	logic               ymajor;
	logic               straight;

	function automatic logic coord_ok(input logic [IN_W-1:0] v, input logic [WIN_W-1:0] lim);
		return !v[IN_W-1] && (v[WIN_W-1:0] < lim);
	endfunction

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_w_q <= WIN_W'(MAX_DIM);
			win_h_q <= WIN_W'(MAX_DIM);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WINDOW_WIDTH:  win_w_q <= cfg.data;
				REG_WINDOW_HEIGHT: win_h_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign w_eff = (win_w_q > WIN_W'(MAX_DIM)) ? WIN_W'(MAX_DIM) : win_w_q;
	assign h_eff = (win_h_q > WIN_W'(MAX_DIM)) ? WIN_W'(MAX_DIM) : win_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			sx_q    <= cmd.start_x;
			sy_q    <= cmd.start_y;
			ex_q    <= cmd.end_x;
			ey_q    <= cmd.end_y;
			color_q <= cmd.pen_color;
		end
	end

	assign in_win = coord_ok(sx_q, w_eff) && coord_ok(ex_q, w_eff)
		&& coord_ok(sy_q, h_eff) && coord_ok(ey_q, h_eff);

	// spans are only used once both points are known to be in window
	assign dx     = {1'b0, ex_q[COORD_W-1:0]} - {1'b0, sx_q[COORD_W-1:0]};
	assign dy     = {1'b0, ey_q[COORD_W-1:0]} - {1'b0, sy_q[COORD_W-1:0]};
	assign dx_neg = -dx;
	assign dy_neg = -dy;

	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			sxn_q <= dx[COORD_W];
			syn_q <= dy[COORD_W];
			adx_q <= dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
			ady_q <= dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
		end
	end

	// equal spans step along rows
	assign ymajor   = !(adx_q > ady_q);
	assign straight = (adx_q == '0) || (ady_q == '0);

	always_comb begin
		if (ymajor) begin
			load_data.a_start = sy_q[COORD_W-1:0];
			load_data.a_end   = ey_q[COORD_W-1:0];
			load_data.b_start = sx_q[COORD_W-1:0];
			load_data.dmaj    = ady_q;
			load_data.dmin    = adx_q;
			load_data.sa_neg  = syn_q;
			load_data.sb_neg  = sxn_q;
		end else begin
			load_data.a_start = sx_q[COORD_W-1:0];
			load_data.a_end   = ex_q[COORD_W-1:0];
			load_data.b_start = sy_q[COORD_W-1:0];
			load_data.dmaj    = adx_q;
			load_data.dmin    = ady_q;
			load_data.sa_neg  = sxn_q;
			load_data.sb_neg  = syn_q;
		end
		load_data.ymajor = ymajor;
		// reversed straight runs go from the smaller coordinate up
		if (straight && load_data.sa_neg) begin
			load_data.a_start = ymajor ? ey_q[COORD_W-1:0] : ex_q[COORD_W-1:0];
			load_data.a_end   = ymajor ? sy_q[COORD_W-1:0] : sx_q[COORD_W-1:0];
			load_data.sa_neg  = 1'b0;
		end
	end

	blr_stepper u_stepper (
		.clk       (clk),
		.load_data (load_data),
		.ctrl      (step_ctrl),
		.pix_x     (step_x),
		.pix_y     (step_y),
		.at_end    (at_end)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = in_win ? S_SETUP : S_REJECT;
			end
			S_SETUP: begin
				state_d = S_RUN;
			end
			S_RUN: begin
				if (pixel.ready && at_end) begin
					state_d = S_IDLE;
				end
			end
			S_REJECT: begin
				if (pixel.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready         = 1'b0;
		pixel.valid       = 1'b0;
		pixel.pixel_x     = '0;
		pixel.pixel_y     = '0;
		pixel.pixel_color = '0;
		pixel.status      = STATUS_OK;
		pixel.last        = 1'b0;
		step_ctrl.load    = 1'b0;
		step_ctrl.advance = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				cmd.ready = 1'b1;
			end
			S_CHECK: ;
			S_SETUP: begin
				step_ctrl.load = 1'b1;
			end
			S_RUN: begin
				pixel.valid       = 1'b1;
				pixel.pixel_x     = step_x;
				pixel.pixel_y     = step_y;
				pixel.pixel_color = color_q;
				pixel.last        = at_end;
				step_ctrl.advance = pixel.ready && !at_end;
			end
			S_REJECT: begin
				pixel.valid  = 1'b1;
				pixel.status = STATUS_REJECT;
				pixel.last   = 1'b1;
			end
			default: ;
		endcase
	end

	`ASSERT_NEXT(a_busy_after_cmd, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready)
	`ASSERT_IMPLIES(a_pixel_in_window, clk, arst_n, pixel.valid && (pixel.status == STATUS_OK), ({1'b0, pixel.pixel_x} < w_eff) && ({1'b0, pixel.pixel_y} < h_eff))
	`ASSERT_NEXT(a_idle_after_last, clk, arst_n, pixel.valid && pixel.ready && pixel.last, cmd.ready)

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// testbench of bresenham_line_rasterizer: line commands in, pixels checked against an
// in-bench rasterizer, window registers written between phases
// depends on blr_pkg, the blr channel interfaces and the rtl of the block

module testbench;
	import blr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_500_000;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned MAX_GAP = 13;
	localparam int ITEMS_PER_PHASE = 36;
	localparam int RANDOM_PHASES = 7;

	// indexes past the register list, which the block ignores
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef struct packed {
		logic signed [IN_W-1:0] start_x;
		logic signed [IN_W-1:0] start_y;
		logic signed [IN_W-1:0] end_x;
		logic signed [IN_W-1:0] end_y;
		logic [COLOR_W-1:0]     pen_color;
	} line_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
		logic               status;
		logic               last;
	} pixel_t;

	logic clk;
	logic arst_n;

	blr_cmd_if cmd_bus();
	blr_pix_if pix_bus();
	blr_cfg_if cfg_bus();

	bresenham_line_rasterizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.pixel  (pix_bus)
	);

	// window registers as the block should hold them
	logic [WIN_W-1:0] win_w;
	logic [WIN_W-1:0] win_h;

	pixel_t pending_pixels[$];
	int unsigned faults = 0;
	int unsigned cycle_count = 0;

	bit src_idle = 1'b1;
	logic sink_idle = 1'b1;
	int sink_wait = 0;
	logic hold_on = 1'b0;
	int hold_len = 0;
	event hold_start;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int eff_dim(logic [WIN_W-1:0] r);
		return (r > MAX_DIM) ? MAX_DIM : int'(r);
	endfunction

	function automatic void queue_pixel(int x, int y, logic [COLOR_W-1:0] color,
			logic status, logic last);
		pixel_t p;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.color = color;
		p.status = status;
		p.last = last;
		pending_pixels.push_back(p);
	endfunction

	// expected pixels of one command under the current window
	function automatic void rasterize_line(line_t ln);
		int x0, y0, x1, y1, w, h, lo, hi, i, dx, dy, sx, sy, err, x, y;
		x0 = $signed(ln.start_x);
		y0 = $signed(ln.start_y);
		x1 = $signed(ln.end_x);
		y1 = $signed(ln.end_y);
		w = eff_dim(win_w);
		h = eff_dim(win_h);
		if (x0 < 0 || x0 >= w || y0 < 0 || y0 >= h ||
				x1 < 0 || x1 >= w || y1 < 0 || y1 >= h) begin
			queue_pixel(0, 0, '0, STATUS_REJECT, 1'b1);
			return;
		end
		if (x0 == x1) begin
			lo = (y0 < y1) ? y0 : y1;
			hi = (y0 < y1) ? y1 : y0;
			for (i = lo; i <= hi; i++)
				queue_pixel(x0, i, ln.pen_color, STATUS_OK, i == hi);
			return;
		end
		if (y0 == y1) begin
			lo = (x0 < x1) ? x0 : x1;
			hi = (x0 < x1) ? x1 : x0;
			for (i = lo; i <= hi; i++)
				queue_pixel(i, y0, ln.pen_color, STATUS_OK, i == hi);
			return;
		end
		dx = x1 - x0;
		dy = y1 - y0;
		sx = 1;
		sy = 1;
		if (dx < 0) begin
			dx = -dx;
			sx = -1;
		end
		if (dy < 0) begin
			dy = -dy;
			sy = -1;
		end
		dx = 2 * dx;
		dy = 2 * dy;
		x = x0;
		y = y0;
		queue_pixel(x, y, ln.pen_color, STATUS_OK, 1'b0);
		if (dx > dy) begin
			err = dy - dx / 2;
			while (x != x1) begin
				if (err >= 0) begin
					y += sy;
					err -= dx;
				end
				x += sx;
				err += dy;
				queue_pixel(x, y, ln.pen_color, STATUS_OK, x == x1);
			end
		end else begin
			// equal spans land here and step along rows
			err = dx - dy / 2;
			while (y != y1) begin
				if (err >= 0) begin
					x += sx;
					err -= dy;
				end
				y += sy;
				err += dx;
				queue_pixel(x, y, ln.pen_color, STATUS_OK, y == y1);
			end
		end
	endfunction

	function automatic line_t line_of(int x0, int y0, int x1, int y1, int color);
		line_t ln;
		ln.start_x = IN_W'(x0);
		ln.start_y = IN_W'(y0);
		ln.end_x = IN_W'(x1);
		ln.end_y = IN_W'(y1);
		ln.pen_color = COLOR_W'(color);
		return ln;
	endfunction

	// mostly lines inside the window, with some rejects and raw noise
	function automatic line_t random_line();
		int w, h, pick, x0, y0, x1, y1, d, t;
		w = eff_dim(win_w);
		h = eff_dim(win_h);
		pick = $urandom_range(0, 99);
		x0 = $urandom_range(0, w - 1);
		y0 = $urandom_range(0, h - 1);
		x1 = $urandom_range(0, w - 1);
		y1 = $urandom_range(0, h - 1);
		if (pick < 10) begin
			x0 = $urandom_range(0, 255);
			y0 = $urandom_range(0, 255);
			x1 = $urandom_range(0, 255);
			y1 = $urandom_range(0, 255);
		end else if (pick < 15) begin
			// one coordinate just off the window
			case ($urandom_range(0, 3))
				0: x1 = w;
				1: y1 = h;
				2: x0 = -1;
				default: y0 = -1;
			endcase
		end else if (pick < 27) begin
			x1 = x0;
		end else if (pick < 39) begin
			y1 = y0;
		end else if (pick < 43) begin
			x1 = x0;
			y1 = y0;
		end else if (pick < 51 && w > 1 && h > 1) begin
			d = $urandom_range(1, ((w < h) ? w : h) - 1);
			x0 = $urandom_range(0, w - 1 - d);
			y0 = $urandom_range(0, h - 1 - d);
			x1 = x0 + d;
			y1 = y0 + d;
			if ($urandom_range(0, 1)) begin
				t = x0;
				x0 = x1;
				x1 = t;
			end
			if ($urandom_range(0, 1)) begin
				t = y0;
				y0 = y1;
				y1 = t;
			end
		end
		return line_of(x0, y0, x1, y1, $urandom_range(0, 255));
	endfunction

	task automatic send_line(line_t ln);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap != 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.start_x <= ln.start_x;
		cmd_bus.start_y <= ln.start_y;
		cmd_bus.end_x <= ln.end_x;
		cmd_bus.end_y <= ln.end_y;
		cmd_bus.pen_color <= ln.pen_color;
		do @(posedge clk); while (!cmd_bus.ready);
		rasterize_line(ln);
	endtask

	// stop offering commands and wait for every expected pixel
	task automatic settle();
		cmd_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		settle();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= WIN_W'(value);
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_WINDOW_WIDTH)
			win_w = WIN_W'(value);
		else if (idx == REG_WINDOW_HEIGHT)
			win_h = WIN_W'(value);
	endtask

	task automatic test_default_window();
		send_line(line_of(0, 0, 63, 63, 255));
		send_line(line_of(63, 0, 0, 63, 0));
		send_line(line_of(5, 40, 5, 2, 17));
		send_line(line_of(60, 7, 3, 7, 200));
		send_line(line_of(10, 10, 10, 10, 85));
		send_line(line_of(0, 0, 63, 5, 170));
		send_line(line_of(2, 63, 9, 0, 1));
		send_line(line_of(63, 63, 0, 62, 128));
		send_line(line_of(-128, 0, 1, 1, 255));
		send_line(line_of(0, 0, 64, 3, 9));
		send_line(line_of(127, 127, 0, 0, 66));
		send_line(line_of(0, 0, 0, -1, 33));
	endtask

	task automatic test_window_extremes();
		// values above the maximum act as the maximum
		write_reg(REG_WINDOW_WIDTH, 127);
		write_reg(REG_WINDOW_HEIGHT, 127);
		send_line(line_of(0, 63, 63, 0, 90));
		send_line(line_of(0, 64, 0, 0, 91));
		write_reg(REG_WINDOW_WIDTH, 1);
		write_reg(REG_WINDOW_HEIGHT, 1);
		send_line(line_of(0, 0, 0, 0, 92));
		send_line(line_of(1, 0, 0, 0, 93));
		// a zero window rejects everything
		write_reg(REG_WINDOW_WIDTH, 0);
		send_line(line_of(0, 0, 0, 0, 94));
		write_reg(REG_WINDOW_WIDTH, 64);
		write_reg(REG_WINDOW_HEIGHT, 0);
		send_line(line_of(3, 0, 3, 0, 95));
		write_reg(REG_SPARE_A, 127);
		write_reg(REG_SPARE_B, 64);
		send_line(line_of(3, 0, 3, 0, 96));
		write_reg(REG_WINDOW_HEIGHT, 64);
		send_line(line_of(3, 0, 3, 0, 97));
	endtask

	task automatic test_stalled_output();
		src_idle = 1'b0;
		hold_len = 600;
		-> hold_start;
		for (int i = 0; i < 8; i++)
			send_line(line_of(0, i * 7, 63, i * 7, $urandom_range(0, 255)));
		src_idle = 1'b1;
	endtask

	task automatic test_random_lines();
		int widths[RANDOM_PHASES] = '{64, 0, 127, 1, 64, 0, 37};
		int heights[RANDOM_PHASES] = '{64, 0, 127, 64, 1, 0, 9};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// zero in the tables means a random window size
			write_reg(REG_WINDOW_WIDTH,
				(widths[p] != 0) ? widths[p] : $urandom_range(1, 127));
			write_reg(REG_WINDOW_HEIGHT,
				(heights[p] != 0) ? heights[p] : $urandom_range(1, 127));
			src_idle = (p % 4 == 0) || (p % 4 == 2);
			sink_idle <= (p % 4 == 0) || (p % 4 == 1);
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_line(random_line());
		end
		sink_idle <= 1'b1;
		src_idle = 1'b1;
	endtask

	// long hold-off of the pixel sink, counted here
	always begin
		@(hold_start);
		hold_on <= 1'b1;
		repeat (hold_len) @(posedge clk);
		hold_on <= 1'b0;
	end

	always @(posedge clk) begin
		if (pix_bus.valid && pix_bus.ready)
			sink_wait = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
		else if (sink_wait != 0)
			sink_wait--;
		pix_bus.ready <= (sink_wait == 0) && !hold_on;
	end

	always @(posedge clk) begin : check_pixels
		pixel_t got;
		pixel_t want;
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			got.x = pix_bus.pixel_x;
			got.y = pix_bus.pixel_y;
			got.color = pix_bus.pixel_color;
			got.status = pix_bus.status;
			got.last = pix_bus.last;
			if (pending_pixels.size() == 0) begin
				faults++;
				if (faults <= MAX_REPORTS)
					$display("unexpected pixel x=%0d y=%0d color=%0d st=%0b last=%0b",
						got.x, got.y, got.color, got.status, got.last);
			end else begin
				want = pending_pixels.pop_front();
				if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
						got.status !== want.status || got.last !== want.last) begin
					faults++;
					if (faults <= MAX_REPORTS) begin
						$display("pixel mismatch: expected x=%0d y=%0d color=%0d st=%0b last=%0b",
							want.x, want.y, want.color, want.status, want.last);
						$display("                got      x=%0d y=%0d color=%0d st=%0b last=%0b",
							got.x, got.y, got.color, got.status, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.start_x = '0;
		cmd_bus.start_y = '0;
		cmd_bus.end_x = '0;
		cmd_bus.end_y = '0;
		cmd_bus.pen_color = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		pix_bus.ready = 1'b0;
		win_w = WIN_W'(MAX_DIM);
		win_h = WIN_W'(MAX_DIM);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_window_extremes();
		test_stalled_output();
		test_random_lines();

		settle();
		repeat (16) @(posedge clk);
		if (faults == 0 && pending_pixels.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
